FILE: hw/rtl/brsq_pkg.sv
package brsq_pkg;

  localparam int unsigned CAPACITY_BITS_DEFAULT = 65536;
  localparam int unsigned INDEX_SPAN = 65536;
  localparam int unsigned INDEX_W = 16;
  localparam int unsigned END_W = 17;
  localparam int unsigned BYTE_AW = 13;
  localparam int unsigned BYTE_SPAN = 8192;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam logic [7:0] BYTE_MASK = 8'hFF;

  typedef enum logic [1:0] {
    CMD_SET_BIT   = 2'd0,
    CMD_GET_BIT   = 2'd1,
    CMD_SET_RANGE = 2'd2,
    CMD_ANY_RANGE = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RUN
  } state_t;

  // Decoded request handed from the front to the back.
  typedef struct packed {
    logic               write;
    logic               value;
    logic               skip;
    logic               err;
    logic [BYTE_AW-1:0] first;
    logic [BYTE_AW-1:0] last;
    logic [7:0]         first_mask;
    logic [7:0]         last_mask;
  } op_t;

  typedef struct packed {
    logic answer_bit;
    logic range_error;
  } res_t;

endpackage

FILE: hw/rtl/brsq_fifo.sv
module brsq_fifo #(
  parameter int unsigned W = 2,
  parameter int unsigned DEPTH = brsq_pkg::QUEUE_DEPTH
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         wr,
  input  logic [W-1:0] wdata,
  input  logic         rd,
  output logic [W-1:0] rdata,
  output logic         empty,
  output logic         full
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [W-1:0]  slots [DEPTH];
  logic [PW-1:0] wptr;
  logic [PW-1:0] rptr;
  logic [CW-1:0] count;
  logic          do_wr;
  logic          do_rd;

  assign empty = (count == CW'(0));
  assign full  = (count == CW'(DEPTH));
  assign do_wr = wr && !full;
  assign do_rd = rd && !empty;
  assign rdata = slots[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + PW'(1);
      end
      if (do_rd) begin
        rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + PW'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CW'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wptr] <= wdata;
    end
  end

endmodule

FILE: hw/rtl/brsq_front.sv
module brsq_front #(
  parameter int unsigned CAPACITY_BITS = brsq_pkg::CAPACITY_BITS_DEFAULT
) (
  input  logic [1:0]                  command,
  input  logic [brsq_pkg::INDEX_W-1:0] start_index,
  input  logic [brsq_pkg::END_W-1:0]   end_index,
  input  logic                        bit_value,
  output brsq_pkg::op_t               op
);

  localparam logic [brsq_pkg::END_W-1:0] CLAMP = brsq_pkg::END_W'(
    (CAPACITY_BITS < brsq_pkg::INDEX_SPAN) ? CAPACITY_BITS : brsq_pkg::INDEX_SPAN);

  logic [brsq_pkg::END_W-1:0] s_ext;
  logic [brsq_pkg::END_W-1:0] e_eff;
  logic [brsq_pkg::END_W-1:0] e_last;
  logic                       err;
  logic                       is_write;

  assign s_ext = {1'b0, start_index};

  always_comb begin
    err      = 1'b0;
    is_write = 1'b0;
    e_eff    = s_ext + brsq_pkg::END_W'(1);
    case (brsq_pkg::cmd_t'(command))
      brsq_pkg::CMD_SET_BIT: begin
        err      = (s_ext >= CLAMP);
        is_write = 1'b1;
      end
      brsq_pkg::CMD_GET_BIT: begin
        err = (s_ext >= CLAMP);
      end
      brsq_pkg::CMD_SET_RANGE: begin
        e_eff    = (end_index > CLAMP) ? CLAMP : end_index;
        is_write = 1'b1;
      end
      default: begin
        e_eff = (end_index > CLAMP) ? CLAMP : end_index;
      end
    endcase
  end

  assign e_last = e_eff - brsq_pkg::END_W'(1);

  // A single bit is the range [s, s+1); empty and faulty requests skip memory.
  always_comb begin
    op.write      = is_write;
    op.value      = bit_value;
    op.err        = err;
    op.skip       = err || (e_eff <= s_ext);
    op.first      = start_index[brsq_pkg::INDEX_W-1:3];
    op.last       = e_last[brsq_pkg::INDEX_W-1:3];
    op.first_mask = brsq_pkg::BYTE_MASK >> start_index[2:0];
    op.last_mask  = ~(brsq_pkg::BYTE_MASK >> ({1'b0, e_last[2:0]} + 4'd1));
  end

endmodule

FILE: hw/rtl/brsq_back.sv
module brsq_back #(
  parameter int unsigned CAPACITY_BITS = brsq_pkg::CAPACITY_BITS_DEFAULT
) (
  input  logic           clk,
  input  logic           rst,
  input  brsq_pkg::op_t  op,
  input  logic           op_empty,
  output logic           op_pop,
  input  logic           res_full,
  output logic           res_push,
  output brsq_pkg::res_t res,
  output logic           clearing
);

  localparam int unsigned STORE_BYTES = (CAPACITY_BITS + 7) / 8;
  localparam int unsigned DEPTH =
    (STORE_BYTES < brsq_pkg::BYTE_SPAN) ? STORE_BYTES : brsq_pkg::BYTE_SPAN;
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [7:0] mem [DEPTH];

  brsq_pkg::state_t           state;
  brsq_pkg::state_t           state_next;
  brsq_pkg::op_t              op_r;
  logic [brsq_pkg::BYTE_AW-1:0] cur;
  logic [AW-1:0]              clr_addr;
  logic [7:0]                 rdata;

  logic                       we;
  logic [AW-1:0]              waddr;
  logic [7:0]                 wdata;
  logic [AW-1:0]              raddr;
  logic [7:0]                 mask;
  logic                       hit;
  logic                       done;
  logic                       take;
  logic [brsq_pkg::BYTE_AW-1:0] cur_inc;

  assign take    = !op_empty && !res_full;
  assign cur_inc = cur + brsq_pkg::BYTE_AW'(1);
  assign mask    = ((cur == op_r.first) ? op_r.first_mask : brsq_pkg::BYTE_MASK) &
                   ((cur == op_r.last)  ? op_r.last_mask  : brsq_pkg::BYTE_MASK);
  assign hit     = |(rdata & mask);
  assign done    = (cur == op_r.last) || (!op_r.write && hit);
  assign clearing = (state == brsq_pkg::ST_CLEAR);

  always_comb begin
    state_next = state;
    case (state)
      brsq_pkg::ST_CLEAR: begin
        if (clr_addr == AW'(DEPTH - 1)) begin
          state_next = brsq_pkg::ST_IDLE;
        end
      end
      brsq_pkg::ST_IDLE: begin
        if (take && !op.skip) begin
          state_next = brsq_pkg::ST_RUN;
        end
      end
      brsq_pkg::ST_RUN: begin
        if (done) begin
          state_next = brsq_pkg::ST_IDLE;
        end
      end
      default: state_next = brsq_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    op_pop   = 1'b0;
    res_push = 1'b0;
    res      = '0;
    we       = 1'b0;
    waddr    = cur[AW-1:0];
    wdata    = (rdata & ~mask) | ({8{op_r.value}} & mask);
    raddr    = op.first[AW-1:0];
    case (state)
      brsq_pkg::ST_CLEAR: begin
        we    = 1'b1;
        waddr = clr_addr;
        wdata = '0;
      end
      brsq_pkg::ST_IDLE: begin
        if (take) begin
          op_pop = 1'b1;
          if (op.skip) begin
            res_push        = 1'b1;
            res.range_error = op.err;
          end
        end
      end
      brsq_pkg::ST_RUN: begin
        we    = op_r.write;
        raddr = done ? cur[AW-1:0] : cur_inc[AW-1:0];
        if (done) begin
          res_push       = 1'b1;
          res.answer_bit = !op_r.write && hit;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= brsq_pkg::ST_CLEAR;
      clr_addr <= '0;
    end else begin
      state <= state_next;
      if (state == brsq_pkg::ST_CLEAR) begin
        clr_addr <= clr_addr + AW'(1);
      end
    end
  end

  // Latch the request and advance one byte per cycle through the walk.
  always_ff @(posedge clk) begin
    if (state == brsq_pkg::ST_IDLE && take) begin
      op_r <= op;
      cur  <= op.first;
    end else if (state == brsq_pkg::ST_RUN && !done) begin
      cur <= cur_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/bitmap_range_set_query.sv
// Channel   Direction  Handshake        Fields
// request   in         push / full      command, start_index, end_index, bit_value
// result    out        empty / pop      answer_bit, range_error
//
// Set and get in the back end make one memory read, then compare or write.
// Range commands make one read, then walk the bytes of the range; any stops at the first set bit.
// Empty ranges and out-of-range indices touch no memory.
// After reset a clearing pass zeroes the byte memory, one byte a cycle; it covers
// min(ceil(CAPACITY_BITS/8), 8192) bytes, and full stays high while it runs.
// Two-entry queues on the request and result sides let either side stall alone.
module bitmap_range_set_query #(
  parameter int unsigned CAPACITY_BITS = brsq_pkg::CAPACITY_BITS_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  output logic                        full,
  input  logic [1:0]                  command,
  input  logic [brsq_pkg::INDEX_W-1:0] start_index,
  input  logic [brsq_pkg::END_W-1:0]   end_index,
  input  logic                        bit_value,
  output logic                        empty,
  input  logic                        pop,
  output logic                        answer_bit,
  output logic                        range_error
);

  localparam int unsigned OP_W  = $bits(brsq_pkg::op_t);
  localparam int unsigned RES_W = $bits(brsq_pkg::res_t);

  brsq_pkg::op_t  op_in;
  brsq_pkg::op_t  op_out;
  brsq_pkg::res_t res_in;
  brsq_pkg::res_t res_out;
  logic           op_full;
  logic           op_empty;
  logic           op_pop;
  logic           res_full;
  logic           res_push;
  logic           clearing;

  assign full = op_full || clearing;

  brsq_front #(
    .CAPACITY_BITS(CAPACITY_BITS)
  ) u_front (
    .command    (command),
    .start_index(start_index),
    .end_index  (end_index),
    .bit_value  (bit_value),
    .op         (op_in)
  );

  brsq_fifo #(
    .W    (OP_W),
    .DEPTH(brsq_pkg::QUEUE_DEPTH)
  ) u_op_queue (
    .clk  (clk),
    .rst  (rst),
    .wr   (push && !clearing),
    .wdata(op_in),
    .rd   (op_pop),
    .rdata(op_out),
    .empty(op_empty),
    .full (op_full)
  );

  brsq_back #(
    .CAPACITY_BITS(CAPACITY_BITS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .op      (op_out),
    .op_empty(op_empty),
    .op_pop  (op_pop),
    .res_full(res_full),
    .res_push(res_push),
    .res     (res_in),
    .clearing(clearing)
  );

  brsq_fifo #(
    .W    (RES_W),
    .DEPTH(brsq_pkg::QUEUE_DEPTH)
  ) u_res_queue (
    .clk  (clk),
    .rst  (rst),
    .wr   (res_push),
    .wdata(res_in),
    .rd   (pop),
    .rdata(res_out),
    .empty(empty),
    .full (res_full)
  );

  assign answer_bit  = res_out.answer_bit;
  assign range_error = res_out.range_error;

endmodule

FILE: dv/tb_bitmap_range_set_query.sv
`timescale 1ns / 100ps

module tb_bitmap_range_set_query;

  localparam int unsigned CAP_BITS = brsq_pkg::CAPACITY_BITS_DEFAULT;
  localparam int unsigned SPAN = brsq_pkg::INDEX_SPAN;
  localparam int unsigned CHUNK_ITEMS = 800;
  localparam int unsigned TAIL_ITEMS = 150;
  localparam int unsigned MAX_REPORTS = 10;
  localparam int unsigned RESULT_HOLD_CYCLES = 200;
  localparam int unsigned SETTLE_CYCLES = 50;
  localparam int unsigned WIDE_SPAN = 1024;

  typedef struct {
    brsq_pkg::cmd_t                       command;
    logic [brsq_pkg::INDEX_W-1:0]         start_idx;
    logic [brsq_pkg::END_W-1:0]           end_idx;
    logic                                 value;
  } bitmap_req_t;

  typedef struct {
    bitmap_req_t    req;
    brsq_pkg::res_t res;
  } answer_t;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         push = 1'b0;
  logic                         full;
  logic [1:0]                   command = brsq_pkg::CMD_SET_BIT;
  logic [brsq_pkg::INDEX_W-1:0] start_index = '0;
  logic [brsq_pkg::END_W-1:0]   end_index = '0;
  logic                         bit_value = 1'b0;
  logic                         empty;
  logic                         pop = 1'b0;
  logic                         answer_bit;
  logic                         range_error;

  bitmap_req_t pending_reqs[$];
  answer_t     expected_answers[$];
  bit          bitmap_bits [CAP_BITS];

  int unsigned hot_base = 0;
  int unsigned fail_cnt = 0;
  int unsigned checked_cnt = 0;
  int unsigned cmd_cnt [4] = '{0, 0, 0, 0};
  int unsigned any_hits = 0;
  int unsigned wide_cnt = 0;
  int unsigned full_stall_cycles = 0;
  int unsigned send_idle_left = 0;
  int unsigned send_idle_pct = 0;
  int unsigned send_cyc = 0;
  int unsigned recv_idle_left = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned recv_cyc = 0;
  int unsigned hold_left = 0;
  bit          hold_results_req = 1'b0;
  bit          tail_phase = 1'b0;
  answer_t     accepted;
  answer_t     oldest;

  bitmap_range_set_query dut (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .command     (command),
    .start_index (start_index),
    .end_index   (end_index),
    .bit_value   (bit_value),
    .empty       (empty),
    .pop         (pop),
    .answer_bit  (answer_bit),
    .range_error (range_error)
  );

  always #10 clk = ~clk;

  // Apply one request to the shadow bitmap and return the answer it produces.
  function automatic brsq_pkg::res_t bitmap_apply(bitmap_req_t r);
    brsq_pkg::res_t res;
    int unsigned    lo;
    int unsigned    hi;
    res = '0;
    lo = 32'(r.start_idx);
    hi = (32'(r.end_idx) > CAP_BITS) ? CAP_BITS : 32'(r.end_idx);
    case (r.command)
      brsq_pkg::CMD_SET_BIT, brsq_pkg::CMD_GET_BIT: begin
        if (lo >= CAP_BITS) begin
          res.range_error = 1'b1;
        end else if (r.command == brsq_pkg::CMD_SET_BIT) begin
          bitmap_bits[lo] = r.value;
        end else begin
          res.answer_bit = bitmap_bits[lo];
        end
      end
      brsq_pkg::CMD_SET_RANGE: begin
        for (int unsigned i = lo; i < hi; i++) bitmap_bits[i] = r.value;
      end
      default: begin
        for (int unsigned i = lo; i < hi; i++) begin
          if (bitmap_bits[i]) begin
            res.answer_bit = 1'b1;
            break;
          end
        end
      end
    endcase
    return res;
  endfunction

  function automatic bitmap_req_t random_request();
    bitmap_req_t r;
    int unsigned pick;
    int unsigned s;
    int unsigned e;
    bit          wide;
    wide = 1'b0;
    pick = $urandom_range(0, 99);
    if (pick < 25) r.command = brsq_pkg::CMD_SET_BIT;
    else if (pick < 50) r.command = brsq_pkg::CMD_GET_BIT;
    else if (pick < 70) r.command = brsq_pkg::CMD_SET_RANGE;
    else r.command = brsq_pkg::CMD_ANY_RANGE;
    // Keep indices in a small window so any-queries see both sparse and dense bits;
    // a quarter of the moves land against the top of the map.
    if ($urandom_range(0, 49) == 0) begin
      hot_base = ($urandom_range(0, 3) == 0) ? SPAN - 256
                                             : $urandom_range(0, SPAN - 256);
    end
    s = hot_base + $urandom_range(0, 255);
    pick = $urandom_range(0, 99);
    if (r.command inside {brsq_pkg::CMD_SET_BIT, brsq_pkg::CMD_GET_BIT}) begin
      e = $urandom_range(0, SPAN);
    end else if (pick < 3) begin
      e = $urandom_range(s, SPAN);
      wide = 1'b1;
    end else if (pick < 15) begin
      e = (s > 20) ? s - $urandom_range(0, 20) : 0;
    end else if (pick < 25 && s >= SPAN - 512) begin
      e = SPAN;
    end else begin
      e = s + $urandom_range(1, 40);
    end
    if (e > SPAN) e = SPAN;
    r.start_idx = brsq_pkg::INDEX_W'(s);
    r.end_idx = brsq_pkg::END_W'(e);
    // Wide writes mostly clear, so the map does not saturate.
    r.value = wide ? ($urandom_range(0, 3) == 0) : 1'($urandom_range(0, 1));
    return r;
  endfunction

  task automatic queue_req(brsq_pkg::cmd_t c, int unsigned s, int unsigned e, logic v);
    bitmap_req_t r;
    r.command = c;
    r.start_idx = brsq_pkg::INDEX_W'(s);
    r.end_idx = brsq_pkg::END_W'(e);
    r.value = v;
    pending_reqs.push_back(r);
  endtask

  task automatic drain_all();
    while (pending_reqs.size() != 0 || expected_answers.size() != 0) @(negedge clk);
  endtask

  // Request driver.
  always @(negedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      send_cyc++;
      if (send_cyc % 256 == 0) begin
        case ($urandom_range(0, 2))
          0: send_idle_pct = 0;
          1: send_idle_pct = 8;
          default: send_idle_pct = 30;
        endcase
      end
      if (send_idle_left > 0) begin
        send_idle_left--;
        push <= 1'b0;
      end else if (pending_reqs.size() == 0) begin
        push <= 1'b0;
      end else if (!tail_phase && $urandom_range(0, 99) < send_idle_pct) begin
        send_idle_left = $urandom_range(0, 12);
        push <= 1'b0;
      end else begin
        push <= 1'b1;
        command <= pending_reqs[0].command;
        start_index <= pending_reqs[0].start_idx;
        end_index <= pending_reqs[0].end_idx;
        bit_value <= pending_reqs[0].value;
      end
    end
  end

  // Predict on acceptance; push the expectation before dropping the request.
  always @(posedge clk) begin
    if (!rst && push) begin
      if (full) begin
        full_stall_cycles++;
      end else begin
        accepted.req = pending_reqs[0];
        accepted.res = bitmap_apply(accepted.req);
        expected_answers.push_back(accepted);
        void'(pending_reqs.pop_front());
        cmd_cnt[accepted.req.command]++;
        if (accepted.req.command == brsq_pkg::CMD_ANY_RANGE && accepted.res.answer_bit) begin
          any_hits++;
        end
        if (accepted.req.command inside {brsq_pkg::CMD_SET_RANGE, brsq_pkg::CMD_ANY_RANGE} &&
            32'(accepted.req.end_idx) > 32'(accepted.req.start_idx) + WIDE_SPAN) begin
          wide_cnt++;
        end
      end
    end
  end

  // Result receiver.
  always @(negedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      recv_cyc++;
      if (recv_cyc % 256 == 128) begin
        case ($urandom_range(0, 2))
          0: recv_idle_pct = 0;
          1: recv_idle_pct = 8;
          default: recv_idle_pct = 30;
        endcase
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else if (hold_results_req) begin
        hold_results_req = 1'b0;
        hold_left = RESULT_HOLD_CYCLES - 1;
        pop <= 1'b0;
      end else if (recv_idle_left > 0) begin
        recv_idle_left--;
        pop <= 1'b0;
      end else if (!tail_phase && $urandom_range(0, 99) < recv_idle_pct) begin
        recv_idle_left = $urandom_range(0, 12);
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // Result checker.
  always @(posedge clk) begin
    if (!rst && pop && !empty) begin
      checked_cnt++;
      if (expected_answers.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= MAX_REPORTS) begin
          $display("%0t: unexpected result answer_bit=%b range_error=%b",
                   $time, answer_bit, range_error);
        end
      end else begin
        oldest = expected_answers.pop_front();
        if (answer_bit !== oldest.res.answer_bit ||
            range_error !== oldest.res.range_error) begin
          fail_cnt++;
          if (fail_cnt <= MAX_REPORTS) begin
            $display("%0t: %s start=%0d end=%0d value=%b:", $time,
                     oldest.req.command.name(), oldest.req.start_idx,
                     oldest.req.end_idx, oldest.req.value);
            $display("  expected answer_bit=%b range_error=%b, got answer_bit=%b range_error=%b",
                     oldest.res.answer_bit, oldest.res.range_error,
                     answer_bit, range_error);
          end
        end
      end
    end
  end

  initial begin
    repeat (9) @(negedge clk);
    rst <= 1'b0;

    // Edges of the map, empty and reversed ranges, partial and whole bytes.
    queue_req(brsq_pkg::CMD_GET_BIT, 0, 0, 1'b0);
    queue_req(brsq_pkg::CMD_ANY_RANGE, 0, SPAN, 1'b0);
    queue_req(brsq_pkg::CMD_SET_BIT, 0, 0, 1'b1);
    queue_req(brsq_pkg::CMD_SET_BIT, SPAN - 1, SPAN, 1'b1);
    queue_req(brsq_pkg::CMD_GET_BIT, 0, 0, 1'b0);
    queue_req(brsq_pkg::CMD_GET_BIT, SPAN - 1, 0, 1'b0);
    queue_req(brsq_pkg::CMD_ANY_RANGE, SPAN - 1, SPAN, 1'b0);
    queue_req(brsq_pkg::CMD_ANY_RANGE, 1, SPAN - 1, 1'b0);
    queue_req(brsq_pkg::CMD_ANY_RANGE, 5, 5, 1'b0);
    queue_req(brsq_pkg::CMD_ANY_RANGE, 100, 50, 1'b0);
    queue_req(brsq_pkg::CMD_SET_RANGE, 10, 10, 1'b1);
    queue_req(brsq_pkg::CMD_SET_RANGE, 200, 100, 1'b1);
    queue_req(brsq_pkg::CMD_GET_BIT, 10, 0, 1'b0);
    queue_req(brsq_pkg::CMD_SET_RANGE, 3, 13, 1'b1);
    queue_req(brsq_pkg::CMD_GET_BIT, 2, 0, 1'b0);
    queue_req(brsq_pkg::CMD_GET_BIT, 12, 0, 1'b0);
    queue_req(brsq_pkg::CMD_ANY_RANGE, 13, 16, 1'b0);
    queue_req(brsq_pkg::CMD_SET_RANGE, 16, 24, 1'b1);
    queue_req(brsq_pkg::CMD_SET_RANGE, SPAN - 6, SPAN, 1'b1);
    queue_req(brsq_pkg::CMD_SET_BIT, SPAN - 1, 0, 1'b0);
    queue_req(brsq_pkg::CMD_ANY_RANGE, SPAN - 1, SPAN, 1'b0);
    queue_req(brsq_pkg::CMD_SET_RANGE, 0, SPAN, 1'b0);
    queue_req(brsq_pkg::CMD_ANY_RANGE, 0, SPAN, 1'b0);
    queue_req(brsq_pkg::CMD_SET_RANGE, 20, 23, 1'b1);
    queue_req(brsq_pkg::CMD_ANY_RANGE, 22, 23, 1'b0);
    drain_all();

    // Stall the result side while requests keep coming, to back up the block.
    hold_results_req = 1'b1;
    for (int unsigned n = 0; n < CHUNK_ITEMS; n++) pending_reqs.push_back(random_request());
    drain_all();

    for (int unsigned n = 0; n < CHUNK_ITEMS; n++) pending_reqs.push_back(random_request());
    while (pending_reqs.size() != 0) @(negedge clk);

    tail_phase = 1'b1;
    for (int unsigned n = 0; n < TAIL_ITEMS; n++) pending_reqs.push_back(random_request());
    drain_all();
    repeat (SETTLE_CYCLES) @(negedge clk);

    if (expected_answers.size() != 0) begin
      fail_cnt++;
      $display("%0d expected results never arrived", expected_answers.size());
    end
    $display("Ran %0d set, %0d get, %0d set-range and %0d any requests",
             cmd_cnt[brsq_pkg::CMD_SET_BIT], cmd_cnt[brsq_pkg::CMD_GET_BIT],
             cmd_cnt[brsq_pkg::CMD_SET_RANGE], cmd_cnt[brsq_pkg::CMD_ANY_RANGE]);
    $display("Checked %0d results (%0d any hits, %0d wide ranges); full blocked %0d cycles",
             checked_cnt, any_hits, wide_cnt, full_stall_cycles);
    if (fail_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("Timed out with %0d requests pending and %0d results outstanding",
             pending_reqs.size(), expected_answers.size());
    $display("FAILURE");
    $finish;
  end

endmodule
